### rtl/rbwb_pkg.sv
// rbwb_pkg: shared widths, types and register codes for the rotated box
// world bounds pipeline. No dependencies.
package rbwb_pkg;

   // field widths
   localparam int COORD_W   = 32;           // Q16.16 coordinates
   localparam int QUAT_W    = 16;           // Q1.14 quaternion components
   localparam int HALF_W    = 31;           // half extent output
   localparam int COEF_W    = 32;           // Q2.30 matrix coefficient
   localparam int FRAC_Q    = 30;           // fraction bits of a coefficient
   localparam int NUM_W     = 33;           // numerator / norm magnitude
   localparam int DIV_STEPS = 31;           // quotient bits, one per stage
   localparam int DIV_LAT   = DIV_STEPS + 1;
   localparam int AXES      = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic [COEF_W-1:0] ONE_Q30 = COEF_W'(1) << FRAC_Q;

   // configuration register codes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE = 2'd0,
      CSR_OFF_X = 2'd1,
      CSR_OFF_Y = 2'd2,
      CSR_OFF_Z = 2'd3
   } csr_index_type;

   // local box corners, one word per axis
   typedef struct packed {
      logic [AXES-1:0][COORD_W-1:0] lo;
      logic [AXES-1:0][COORD_W-1:0] hi;
   } box_type;

   // rotation matrix, [row][column], Q2.30 two's complement
   typedef logic [AXES-1:0][AXES-1:0][COEF_W-1:0] mat_type;

endpackage

### rtl/rbwb_div.sv
// rbwb_div: pipelined restoring divider, one quotient bit per stage.
// Computes round(num * 2^30 / den) on magnitudes and restores the sign.
// Depends on rbwb_pkg.
module rbwb_div (
   input  logic                         clock,
   input  logic [rbwb_pkg::NUM_W-1:0]   num_mag,
   input  logic                         num_neg,
   input  logic [rbwb_pkg::NUM_W-1:0]   den,
   output logic [rbwb_pkg::COEF_W-1:0]  quot
);
   import rbwb_pkg::*;

   localparam int DVD_W = NUM_W + FRAC_Q;

   logic [DVD_W-1:0]     dvd;
   logic [NUM_W-1:0]     rem_ff [DIV_LAT];
   logic [DIV_STEPS-1:0] low_ff [DIV_LAT];
   logic [NUM_W-1:0]     den_ff [DIV_LAT];
   logic [DIV_STEPS-1:0] quo_ff [DIV_LAT];
   logic                 neg_ff [DIV_LAT];
   logic [NUM_W-1:0]     rem_in [DIV_LAT];
   logic [DIV_STEPS-1:0] quo_in [DIV_LAT];

   // dividend with half the divisor added for round half up
   assign dvd = {num_mag, FRAC_Q'(0)} + DVD_W'(den >> 1);

   // top bits start the remainder; they stay below den since |num| <= den
   always_ff @(posedge clock) begin
      rem_ff[0] <= NUM_W'(dvd[DVD_W-1:DIV_STEPS]);
      low_ff[0] <= dvd[DIV_STEPS-1:0];
      den_ff[0] <= den;
      quo_ff[0] <= '0;
      neg_ff[0] <= num_neg;
   end

   assign rem_in[0] = '0;
   assign quo_in[0] = '0;

   // one compare and subtract per stage
   for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
      logic [NUM_W:0] trial;
      logic           fits;

      always_comb begin
         trial     = {rem_ff[k-1], low_ff[k-1][DIV_STEPS-1]};
         fits      = trial >= {1'b0, den_ff[k-1]};
         rem_in[k] = fits ? NUM_W'(trial - {1'b0, den_ff[k-1]}) : trial[NUM_W-1:0];
         quo_in[k] = {quo_ff[k-1][DIV_STEPS-2:0], fits};
      end

      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in[k];
         low_ff[k] <= {low_ff[k-1][DIV_STEPS-2:0], 1'b0};
         den_ff[k] <= den_ff[k-1];
         quo_ff[k] <= quo_in[k];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   // quotient never exceeds 2^30, so the sign bit is free
   assign quot = neg_ff[DIV_LAT-1] ? -COEF_W'(quo_ff[DIV_LAT-1])
                                   :  COEF_W'(quo_ff[DIV_LAT-1]);

endmodule

### rtl/rbwb_mat.sv
// rbwb_mat: quaternion to rotation matrix front end: products, norm and
// numerators, nine divider lanes, identity for a zero quaternion.
// Depends on rbwb_pkg and rbwb_div.
module rbwb_mat (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [rbwb_pkg::QUAT_W-1:0] quat_x,
   input  logic signed [rbwb_pkg::QUAT_W-1:0] quat_y,
   input  logic signed [rbwb_pkg::QUAT_W-1:0] quat_z,
   input  logic signed [rbwb_pkg::QUAT_W-1:0] quat_w,
   input  rbwb_pkg::box_type                  in_box,
   output logic                              out_valid,
   output rbwb_pkg::box_type                  out_box,
   output rbwb_pkg::mat_type                  out_mat
);
   import rbwb_pkg::*;

   localparam int PROD_W = 2 * QUAT_W;
   localparam int SUM_W  = PROD_W + 3;
   localparam int NUMS   = AXES * AXES;

   // stage 1: input capture
   logic                     v1_ff;
   logic signed [QUAT_W-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   box_type                  box1_ff;

   // stage 2: component products
   logic                     v2_ff;
   box_type                  box2_ff;
   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [PROD_W-1:0] xy_ff, zw_ff, xz_ff, yw_ff, yz_ff, xw_ff;

   // stage 3: norm and numerators
   logic                     v3_ff;
   box_type                  box3_ff;
   logic                     zero3_ff;
   logic [NUM_W-1:0]         n2_ff;
   logic [NUM_W-1:0]         num_mag_ff [NUMS];
   logic                     num_neg_ff [NUMS];

   logic signed [SUM_W-1:0]  sn2;
   logic signed [SUM_W-1:0]  num_in [NUMS];
   logic [COEF_W-1:0]        quot [NUMS];

   // delay line alongside the dividers
   logic [DIV_LAT-1:0]       dl_v_ff;
   logic                     dl_zero_ff [DIV_LAT];
   box_type                  dl_box_ff  [DIV_LAT];

   logic                     vm_ff;
   box_type                  boxm_ff;
   mat_type                  mat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         dl_v_ff <= '0;
         vm_ff   <= 1'b0;
      end else begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         dl_v_ff <= {dl_v_ff[DIV_LAT-2:0], v3_ff};
         vm_ff   <= dl_v_ff[DIV_LAT-1];
      end
   end

   // stage 1 and 2 payload
   always_ff @(posedge clock) begin
      qx_ff   <= quat_x;
      qy_ff   <= quat_y;
      qz_ff   <= quat_z;
      qw_ff   <= quat_w;
      box1_ff <= in_box;
      box2_ff <= box1_ff;
      xx_ff   <= qx_ff * qx_ff;
      yy_ff   <= qy_ff * qy_ff;
      zz_ff   <= qz_ff * qz_ff;
      ww_ff   <= qw_ff * qw_ff;
      xy_ff   <= qx_ff * qy_ff;
      zw_ff   <= qz_ff * qw_ff;
      xz_ff   <= qx_ff * qz_ff;
      yw_ff   <= qy_ff * qw_ff;
      yz_ff   <= qy_ff * qz_ff;
      xw_ff   <= qx_ff * qw_ff;
   end

   // numerators, row-major: entry [i][j] at 3*i+j
   always_comb begin
      sn2 = SUM_W'(xx_ff) + SUM_W'(yy_ff) + SUM_W'(zz_ff) + SUM_W'(ww_ff);
      num_in[0] = sn2 - ((SUM_W'(yy_ff) + SUM_W'(zz_ff)) <<< 1);
      num_in[1] = (SUM_W'(xy_ff) + SUM_W'(zw_ff)) <<< 1;
      num_in[2] = (SUM_W'(xz_ff) - SUM_W'(yw_ff)) <<< 1;
      num_in[3] = (SUM_W'(xy_ff) - SUM_W'(zw_ff)) <<< 1;
      num_in[4] = sn2 - ((SUM_W'(xx_ff) + SUM_W'(zz_ff)) <<< 1);
      num_in[5] = (SUM_W'(yz_ff) + SUM_W'(xw_ff)) <<< 1;
      num_in[6] = (SUM_W'(xz_ff) + SUM_W'(yw_ff)) <<< 1;
      num_in[7] = (SUM_W'(yz_ff) - SUM_W'(xw_ff)) <<< 1;
      num_in[8] = sn2 - ((SUM_W'(xx_ff) + SUM_W'(yy_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      box3_ff  <= box2_ff;
      n2_ff    <= sn2[NUM_W-1:0];
      zero3_ff <= (sn2 == '0);
      for (int e = 0; e < NUMS; e++) begin
         num_neg_ff[e] <= num_in[e][SUM_W-1];
         num_mag_ff[e] <= num_in[e][SUM_W-1] ? NUM_W'(-num_in[e]) : num_in[e][NUM_W-1:0];
      end
   end

   // one divider lane per coefficient
   for (genvar e = 0; e < NUMS; e++) begin : g_lane
      rbwb_div u_div (
         .clock   (clock),
         .num_mag (num_mag_ff[e]),
         .num_neg (num_neg_ff[e]),
         .den     (n2_ff),
         .quot    (quot[e])
      );
   end

   // box and zero flag ride along with the dividers
   always_ff @(posedge clock) begin
      dl_box_ff[0]  <= box3_ff;
      dl_zero_ff[0] <= zero3_ff;
      for (int k = 1; k < DIV_LAT; k++) begin
         dl_box_ff[k]  <= dl_box_ff[k-1];
         dl_zero_ff[k] <= dl_zero_ff[k-1];
      end
   end

   // matrix register, identity when the quaternion is zero
   always_ff @(posedge clock) begin
      boxm_ff <= dl_box_ff[DIV_LAT-1];
      for (int i = 0; i < AXES; i++) begin
         for (int j = 0; j < AXES; j++) begin
            if (dl_zero_ff[DIV_LAT-1]) begin
               mat_ff[i][j] <= (i == j) ? ONE_Q30 : '0;
            end else begin
               mat_ff[i][j] <= quot[AXES*i+j];
            end
         end
      end
   end

   assign out_valid = vm_ff;
   assign out_box   = boxm_ff;
   assign out_mat   = mat_ff;

endmodule

### rtl/rbwb_bound.sv
// rbwb_bound: corner transform back end. Per axis: extreme products, sums,
// rounding, scale, half extent and center with output saturation.
// Depends on rbwb_pkg.
module rbwb_bound (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  rbwb_pkg::box_type                          in_box,
   input  rbwb_pkg::mat_type                          in_mat,
   input  logic [rbwb_pkg::COORD_W-1:0]               scale,
   input  logic [rbwb_pkg::AXES-1:0][rbwb_pkg::COORD_W-1:0] offset,
   output logic                                      out_valid,
   output logic [rbwb_pkg::AXES-1:0][rbwb_pkg::COORD_W-1:0] center,
   output logic [rbwb_pkg::AXES-1:0][rbwb_pkg::HALF_W-1:0]  half,
   output logic                                      bounds_ok
);
   import rbwb_pkg::*;

   localparam int PRD_W  = 2 * COORD_W;          // coordinate times coefficient
   localparam int R_W    = 34;                   // rounded rotated value
   localparam int SC_W   = COORD_W / 2;          // scale half word
   localparam int PS_W   = R_W + SC_W;           // partial scale product
   localparam int V_W    = PS_W + 1;             // signed scaled value
   localparam int D_W    = V_W + 1;              // max minus min
   localparam int HW_W   = D_W - 2;              // half extent, never negative
   localparam int C_W    = HW_W + 3;             // center sum
   localparam int STAGES = 8;

   localparam logic [PRD_W-1:0] RND_Q30 = PRD_W'(1) << (FRAC_Q - 1);
   localparam logic [PS_W-1:0]  RND_Q16 = PS_W'(1) << (SC_W - 1);
   localparam logic signed [C_W-1:0] CTR_MAX = C_W'(32'h7FFF_FFFF);
   localparam logic signed [C_W-1:0] CTR_MIN = -C_W'(32'h8000_0000);
   localparam logic [HW_W-1:0] HALF_MAX = HW_W'(31'h7FFF_FFFF);

   logic [STAGES-1:0] vld_ff;

   logic signed [PRD_W-1:0] plo_ff  [AXES][AXES];
   logic signed [PRD_W-1:0] phi_ff  [AXES][AXES];
   logic signed [PRD_W-1:0] tmin_ff [AXES][AXES];
   logic signed [PRD_W-1:0] tmax_ff [AXES][AXES];
   logic signed [PRD_W-1:0] s_ff    [AXES][2];
   logic [R_W-1:0]          r_ff    [AXES][2];
   logic                    rneg_ff [AXES][2];
   logic [PS_W-1:0]         ph_ff   [AXES][2];
   logic [PS_W-1:0]         pl_ff   [AXES][2];
   logic                    pneg_ff [AXES][2];
   logic signed [V_W-1:0]   v_ff    [AXES][2];
   logic [HW_W-1:0]         half_ff [AXES];
   logic signed [V_W-1:0]   lo_ff   [AXES];

   logic [AXES-1:0][COORD_W-1:0] center_ff;
   logic [AXES-1:0][HALF_W-1:0]  half_out_ff;
   logic                         ok_ff;

   // valid bits, one per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[STAGES-2:0], in_valid};
      end
   end

   // stages 1 to 3: products, per-term extremes, sums over rows
   always_ff @(posedge clock) begin
      for (int i = 0; i < AXES; i++) begin
         for (int j = 0; j < AXES; j++) begin
            plo_ff[i][j]  <= $signed(in_box.lo[i]) * $signed(in_mat[i][j]);
            phi_ff[i][j]  <= $signed(in_box.hi[i]) * $signed(in_mat[i][j]);
            tmin_ff[i][j] <= (plo_ff[i][j] < phi_ff[i][j]) ? plo_ff[i][j] : phi_ff[i][j];
            tmax_ff[i][j] <= (plo_ff[i][j] < phi_ff[i][j]) ? phi_ff[i][j] : plo_ff[i][j];
         end
      end
      for (int j = 0; j < AXES; j++) begin
         s_ff[j][0] <= tmin_ff[0][j] + tmin_ff[1][j] + tmin_ff[2][j];
         s_ff[j][1] <= tmax_ff[0][j] + tmax_ff[1][j] + tmax_ff[2][j];
      end
   end

   // stages 4 to 6: round to Q16.16, then scale; side 0 is min, side 1 max
   for (genvar a = 0; a < AXES; a++) begin : g_axis
      for (genvar sd = 0; sd < 2; sd++) begin : g_side
         logic [PRD_W-1:0] mag;
         logic [PRD_W-1:0] rsum;
         logic [PS_W-1:0]  vmag;

         always_comb begin
            mag  = s_ff[a][sd][PRD_W-1] ? PRD_W'(-s_ff[a][sd]) : PRD_W'(s_ff[a][sd]);
            rsum = mag + RND_Q30;
            vmag = ph_ff[a][sd] + ((pl_ff[a][sd] + RND_Q16) >> SC_W);
         end

         always_ff @(posedge clock) begin
            r_ff[a][sd]    <= rsum[FRAC_Q +: R_W];
            rneg_ff[a][sd] <= s_ff[a][sd][PRD_W-1];
            ph_ff[a][sd]   <= r_ff[a][sd] * scale[COORD_W-1:SC_W];
            pl_ff[a][sd]   <= r_ff[a][sd] * scale[SC_W-1:0];
            pneg_ff[a][sd] <= rneg_ff[a][sd];
            v_ff[a][sd]    <= pneg_ff[a][sd] ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
         end
      end
   end

   // stage 7: half extent, floor of half the span
   always_ff @(posedge clock) begin
      for (int a = 0; a < AXES; a++) begin
         half_ff[a] <= HW_W'((D_W'(v_ff[a][1]) - D_W'(v_ff[a][0])) >>> 1);
         lo_ff[a]   <= v_ff[a][0];
      end
   end

   // stage 8: center, saturation and flag
   always_ff @(posedge clock) begin
      logic signed [C_W-1:0] ctr;
      logic                  ok;
      ok = 1'b1;
      for (int a = 0; a < AXES; a++) begin
         ctr = C_W'($signed(offset[a])) + C_W'(lo_ff[a]) + $signed(C_W'(half_ff[a]));
         if (ctr > CTR_MAX) begin
            center_ff[a] <= CTR_MAX[COORD_W-1:0];
            ok = 1'b0;
         end else if (ctr < CTR_MIN) begin
            center_ff[a] <= CTR_MIN[COORD_W-1:0];
            ok = 1'b0;
         end else begin
            center_ff[a] <= ctr[COORD_W-1:0];
         end
         if (half_ff[a] > HALF_MAX) begin
            half_out_ff[a] <= HALF_MAX[HALF_W-1:0];
            ok = 1'b0;
         end else begin
            half_out_ff[a] <= half_ff[a][HALF_W-1:0];
         end
         if (half_ff[a] == '0) begin
            ok = 1'b0;
         end
      end
      ok_ff <= ok;
   end

   assign out_valid = vld_ff[STAGES-1];
   assign center    = center_ff;
   assign half      = half_out_ff;
   assign bounds_ok = ok_ff;

endmodule

### rtl/rotated_box_world_bounds.sv
// rotated_box_world_bounds: world axis-aligned bounds of a scaled, rotated box.
// Depends on rbwb_pkg, rbwb_mat and rbwb_bound.
//
// Usage:
//   Input: drive the box corners and quaternion on the req_ ports and raise
//   start; the word is taken at every rising edge where start is high and
//   busy is low. busy never rises, so a new word can enter every cycle.
//   Output: each word gives exactly one result, shown on the rsp_ ports for
//   one cycle with rsp_strobe high. The receiver cannot stall; results leave
//   in input order.
//   Pipeline: the 32-stage divider lanes that normalize the matrix
//   (an entry stage, then one quotient bit per stage) plus 12 stages of
//   capture, products, sums, rounding, scaling and saturation lie between
//   the accepting edge and the cycle with rsp_strobe.
//   Throughput: one word per cycle.
//   Configuration: csr_we writes csr_wdata to register csr_index
//   (0 scale, 1..3 offset x/y/z); write only while no word is in flight.
//   Reset: synchronous; clears all stage valid bits so no strobe is
//   produced for words in flight, and restores scale 1.0 and zero offsets.
module rotated_box_world_bounds (
   input  logic                                  clock,
   input  logic                                  reset,
   // request
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [rbwb_pkg::COORD_W-1:0]   req_box_min_x,
   input  logic signed [rbwb_pkg::COORD_W-1:0]   req_box_min_y,
   input  logic signed [rbwb_pkg::COORD_W-1:0]   req_box_min_z,
   input  logic signed [rbwb_pkg::COORD_W-1:0]   req_box_max_x,
   input  logic signed [rbwb_pkg::COORD_W-1:0]   req_box_max_y,
   input  logic signed [rbwb_pkg::COORD_W-1:0]   req_box_max_z,
   input  logic signed [rbwb_pkg::QUAT_W-1:0]    req_quat_x,
   input  logic signed [rbwb_pkg::QUAT_W-1:0]    req_quat_y,
   input  logic signed [rbwb_pkg::QUAT_W-1:0]    req_quat_z,
   input  logic signed [rbwb_pkg::QUAT_W-1:0]    req_quat_w,
   // response
   output logic                                  rsp_strobe,
   output logic signed [rbwb_pkg::COORD_W-1:0]   rsp_center_x,
   output logic signed [rbwb_pkg::COORD_W-1:0]   rsp_center_y,
   output logic signed [rbwb_pkg::COORD_W-1:0]   rsp_center_z,
   output logic [rbwb_pkg::HALF_W-1:0]           rsp_half_x,
   output logic [rbwb_pkg::HALF_W-1:0]           rsp_half_y,
   output logic [rbwb_pkg::HALF_W-1:0]           rsp_half_z,
   output logic                                  rsp_bounds_ok,
   // configuration
   input  logic                                  csr_we,
   input  logic [rbwb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rbwb_pkg::COORD_W-1:0]          csr_wdata
);
   import rbwb_pkg::*;

   logic [COORD_W-1:0]            scale_ff;
   logic [AXES-1:0][COORD_W-1:0]  off_ff;

   logic                          accept;
   box_type                       req_box;
   logic                          mat_valid;
   box_type                       mat_box;
   mat_type                       mat;
   logic [AXES-1:0][COORD_W-1:0]  center;
   logic [AXES-1:0][HALF_W-1:0]   half;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= COORD_W'(32'h0001_0000);
         off_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SCALE: scale_ff  <= csr_wdata;
            CSR_OFF_X: off_ff[0] <= csr_wdata;
            CSR_OFF_Y: off_ff[1] <= csr_wdata;
            CSR_OFF_Z: off_ff[2] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_box.lo = {req_box_min_z, req_box_min_y, req_box_min_x};
   assign req_box.hi = {req_box_max_z, req_box_max_y, req_box_max_x};

   // matrix front end
   rbwb_mat u_mat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .quat_w    (req_quat_w),
      .in_box    (req_box),
      .out_valid (mat_valid),
      .out_box   (mat_box),
      .out_mat   (mat)
   );

   // bounds back end
   rbwb_bound u_bound (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mat_valid),
      .in_box    (mat_box),
      .in_mat    (mat),
      .scale     (scale_ff),
      .offset    (off_ff),
      .out_valid (rsp_strobe),
      .center    (center),
      .half      (half),
      .bounds_ok (rsp_bounds_ok)
   );

   assign rsp_center_x = center[0];
   assign rsp_center_y = center[1];
   assign rsp_center_z = center[2];
   assign rsp_half_x   = half[0];
   assign rsp_half_y   = half[1];
   assign rsp_half_z   = half[2];

endmodule

### bench/tb.sv
// tb: self-checking bench for rotated_box_world_bounds.
// Depends on rbwb_pkg and the rotated_box_world_bounds RTL; predicts each word in-bench.
`timescale 1ns / 100ps

module tb;
   import rbwb_pkg::*;

   typedef struct packed {
      logic [2:0][31:0] bmin;
      logic [2:0][31:0] bmax;
      logic [3:0][15:0] quat;   // x, y, z, w
   } box_word_type;

   typedef struct packed {
      logic [2:0][31:0] center;
      logic [2:0][30:0] half;
      logic             ok;
   } bounds_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_box_min_x = '0, req_box_min_y = '0, req_box_min_z = '0;
   logic signed [31:0] req_box_max_x = '0, req_box_max_y = '0, req_box_max_z = '0;
   logic signed [15:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic rsp_strobe, rsp_bounds_ok;
   logic signed [31:0] rsp_center_x, rsp_center_y, rsp_center_z;
   logic [30:0] rsp_half_x, rsp_half_y, rsp_half_z;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   box_word_type  box_pending[$];
   bounds_type    bounds_due[$];
   logic [31:0]      scale_now;
   logic [2:0][31:0] offset_now;
   logic taken = 1'b0;
   logic calm = 1'b0;        // no idling while set
   int   error_count = 0;
   int   stall_cycles = 0;

   rotated_box_world_bounds DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rounded Q2.30 ratio num/n2, half away from zero
   function automatic longint ratio_q30(longint num, longint n2);
      longint unsigned mag, q;
      mag = (num < 0) ? -num : num;
      q = ((mag << 30) + n2 / 2) / n2;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic bounds_type predict_bounds(box_word_type b);
      longint x, y, z, w, n2;
      longint m[3][3];
      logic signed [127:0] c[3], lo[3], hi[3], s, v, half, ctr;
      logic [127:0] mag, r, sc;
      bounds_type res;
      logic sat;
      logic ok;
      x = $signed(b.quat[0]);
      y = $signed(b.quat[1]);
      z = $signed(b.quat[2]);
      w = $signed(b.quat[3]);
      n2 = x*x + y*y + z*z + w*w;
      sat = 1'b0;
      ok = 1'b1;
      sc = scale_now;
      if (n2 == 0) begin
         foreach (m[i, j]) m[i][j] = (i == j) ? (longint'(1) << 30) : 0;
      end else begin
         m[0][0] = ratio_q30(n2 - 2*(y*y + z*z), n2);
         m[0][1] = ratio_q30(2*(x*y + z*w), n2);
         m[0][2] = ratio_q30(2*(x*z - y*w), n2);
         m[1][0] = ratio_q30(2*(x*y - z*w), n2);
         m[1][1] = ratio_q30(n2 - 2*(x*x + z*z), n2);
         m[1][2] = ratio_q30(2*(y*z + x*w), n2);
         m[2][0] = ratio_q30(2*(x*z + y*w), n2);
         m[2][1] = ratio_q30(2*(y*z - x*w), n2);
         m[2][2] = ratio_q30(n2 - 2*(x*x + y*y), n2);
      end
      // corner k picks max on an axis when that bit of k is set
      for (int k = 0; k < 8; k++) begin
         for (int a = 0; a < 3; a++)
            c[a] = k[a] ? $signed(b.bmax[a]) : $signed(b.bmin[a]);
         for (int j = 0; j < 3; j++) begin
            s = c[0] * 128'(signed'(m[0][j])) + c[1] * 128'(signed'(m[1][j]))
              + c[2] * 128'(signed'(m[2][j]));
            mag = (s < 0) ? -s : s;
            r = (mag + (128'd1 << 29)) >> 30;
            mag = r * (sc >> 16) + ((r * (sc & 128'hFFFF) + 128'h8000) >> 16);
            v = (s < 0) ? -$signed(mag) : $signed(mag);
            if (k == 0 || v < lo[j]) lo[j] = v;
            if (k == 0 || v > hi[j]) hi[j] = v;
         end
      end
      // half extent and center, saturated on output only
      for (int a = 0; a < 3; a++) begin
         half = (hi[a] - lo[a]) >>> 1;
         ctr = $signed(offset_now[a]) + lo[a] + half;
         if (half > 128'sh7FFFFFFF) begin
            half = 128'sh7FFFFFFF;
            sat = 1'b1;
         end
         if (ctr > 128'sh7FFFFFFF) begin
            ctr = 128'sh7FFFFFFF;
            sat = 1'b1;
         end else if (ctr < -128'sh80000000) begin
            ctr = -128'sh80000000;
            sat = 1'b1;
         end
         if (half <= 0) ok = 1'b0;
         res.center[a] = ctr[31:0];
         res.half[a] = half[30:0];
      end
      res.ok = ok && !sat;
      return res;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_SCALE) scale_now = data;
      else offset_now[idx - 1] = data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // driver: one word per start, idles at random unless calm
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (box_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
            box_word_type b;
            b = box_pending.pop_front();
            {req_box_min_z, req_box_min_y, req_box_min_x} <= b.bmin;
            {req_box_max_z, req_box_max_y, req_box_max_x} <= b.bmax;
            {req_quat_w, req_quat_z, req_quat_y, req_quat_x} <= b.quat;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predict accepted words, check each strobed result, watchdog
   always @(posedge clock) begin
      taken <= start && !busy && !reset;
      if (!reset && start && !busy) begin
         box_word_type b;
         b.bmin = {req_box_min_z, req_box_min_y, req_box_min_x};
         b.bmax = {req_box_max_z, req_box_max_y, req_box_max_x};
         b.quat = {req_quat_w, req_quat_z, req_quat_y, req_quat_x};
         bounds_due.push_back(predict_bounds(b));
      end
      if (!reset && rsp_strobe) begin
         if (bounds_due.size() == 0) begin
            report("unexpected word", rsp_center_x, 32'h0);
         end else begin
            bounds_type e;
            e = bounds_due.pop_front();
            if (rsp_center_x !== e.center[0]) report("center_x", rsp_center_x, e.center[0]);
            if (rsp_center_y !== e.center[1]) report("center_y", rsp_center_y, e.center[1]);
            if (rsp_center_z !== e.center[2]) report("center_z", rsp_center_z, e.center[2]);
            if (rsp_half_x !== e.half[0]) report("half_x", rsp_half_x, e.half[0]);
            if (rsp_half_y !== e.half[1]) report("half_y", rsp_half_y, e.half[1]);
            if (rsp_half_z !== e.half[2]) report("half_z", rsp_half_z, e.half[2]);
            if (rsp_bounds_ok !== e.ok) report("bounds_ok", rsp_bounds_ok, e.ok);
         end
      end
      if ((start && !busy) || rsp_strobe || reset) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 5000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         default: return 32'($signed($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   task automatic add_random(int count);
      box_word_type b;
      logic [31:0] p, q;
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(0, 9);
         mode = (mode < 2) ? 0 : (mode < 8) ? 1 : 2;
         for (int a = 0; a < 3; a++) begin
            p = rand_coord(mode);
            q = rand_coord(mode);
            // mostly ordered boxes, some inverted
            if (($signed(p) > $signed(q)) == ($urandom_range(0, 9) != 0)) begin
               b.bmin[a] = q;
               b.bmax[a] = p;
            end else begin
               b.bmin[a] = p;
               b.bmax[a] = q;
            end
         end
         for (int i = 0; i < 4; i++) b.quat[i] = 16'($urandom());
         case ($urandom_range(0, 9))
            0: b.quat = '0;
            1: b.quat = {16'sd16384, 48'd0};
            2: for (int i = 0; i < 4; i++) b.quat[i] = 16'($signed($urandom_range(0, 64)) - 32);
            default: ;
         endcase
         box_pending.push_back(b);
      end
   endtask

   task automatic add_box(logic [31:0] lo, logic [31:0] hi, logic [63:0] quat);
      box_word_type b;
      b.bmin = {3{lo}};
      b.bmax = {3{hi}};
      b.quat = quat;
      box_pending.push_back(b);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (box_pending.size() != 0 || start || bounds_due.size() != 0);
      repeat (50) @(negedge clock);
   endtask

   initial begin
      scale_now = 32'h0001_0000;
      offset_now = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: identity, zero quaternion, extremes, inverted box, axis turns
      add_box(32'hFFFF_0000, 32'h0001_0000, {16'sd16384, 48'd0});
      add_box(32'hFFFF_0000, 32'h0001_0000, 64'd0);
      add_box(32'h8000_0000, 32'h7FFF_FFFF, 64'd0);
      add_box(32'h8000_0000, 32'h7FFF_FFFF, {4{16'h8000}});
      add_box(32'h8000_0000, 32'h7FFF_FFFF, {4{16'h7FFF}});
      add_box(32'h0001_0000, 32'hFFFF_0000, {16'sd16384, 48'd0});
      add_box(32'h0000_1000, 32'h0000_1000, {16'sd16384, 48'd0});
      add_box(32'h0000_0000, 32'h0000_0001, {16'sd11585, 16'sd11585, 32'd0});
      add_box(32'h0002_0000, 32'h0005_0000, {16'sd11585, 16'd0, 16'sd11585, 16'd0});
      add_box(32'h0002_0000, 32'h0005_0000, {16'sd11585, 32'd0, 16'sd11585});
      add_box(32'hFFF0_0000, 32'h0010_0000, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
      add_box(32'h7FFF_FFFF, 32'h8000_0000, {16'd0, 16'd1, 16'd0, 16'd0});
      add_box(32'h0000_0000, 32'h0000_0000, {16'd1, 16'd0, 16'd0, 16'd0});
      add_box(32'hAAAA_AAAA, 32'h5555_5555, {16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
      add_box(32'h5555_5555, 32'hAAAA_AAAA, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
      add_random(180);
      drain();

      // scale zero, tiny and large with edge offsets, 2.5 with none, then random
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_SCALE, 32'd0);
               write_csr(CSR_OFF_X, 32'h7FFF_FFFF);
               write_csr(CSR_OFF_Y, 32'h8000_0000);
               write_csr(CSR_OFF_Z, 32'h0000_0001);
            end
            1: write_csr(CSR_SCALE, 32'd1);
            2: begin
               write_csr(CSR_SCALE, 32'hFFFF_FFFF);
               write_csr(CSR_OFF_X, 32'h8000_0000);
               write_csr(CSR_OFF_Y, 32'h7FFF_FFFF);
               write_csr(CSR_OFF_Z, 32'hFFFF_FFFF);
            end
            3: begin
               write_csr(CSR_SCALE, 32'h0002_8000);
               write_csr(CSR_OFF_X, 32'd0);
               write_csr(CSR_OFF_Y, 32'd0);
               write_csr(CSR_OFF_Z, 32'd0);
            end
            default: begin
               write_csr(CSR_SCALE, $urandom());
               write_csr(CSR_OFF_X, $urandom());
               write_csr(CSR_OFF_Y, $urandom());
               write_csr(CSR_OFF_Z, $urandom());
            end
         endcase
         calm = (ph == 3);
         add_random(170);
         drain();
      end

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
